### rtl/core/rsd_pkg.sv
// types and constants shared by the record sorter
`timescale 1ns / 1ps

package rsd_pkg;

  localparam int unsigned CNT_W = 7;

  typedef enum logic [1:0] {
    ST_RANKED   = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SORT,
    OP_ROTATE
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic        [31:0] roll;
    logic signed [31:0] mark;
  } record_t;

  typedef struct packed {
    cell_op_t          op;
    logic              phase;
    logic [CNT_W-1:0]  count;
    record_t           din;
  } cell_ctrl_t;

endpackage

### rtl/core/rsd_cell.sv
// one table slot with its neighbour compare and swap
`timescale 1ns / 1ps

module rsd_cell #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  rsd_pkg::cell_ctrl_t ctrl,
  input  rsd_pkg::record_t  left_rec,
  input  rsd_pkg::record_t  right_rec,
  input  rsd_pkg::record_t  head_rec,
  input  logic              left_swap,
  output logic              swap_right,
  output rsd_pkg::record_t  rec
);

  localparam logic PAR = 1'(INDEX % 2);
  localparam logic [rsd_pkg::CNT_W-1:0] IDX  = rsd_pkg::CNT_W'(INDEX);
  localparam logic [rsd_pkg::CNT_W-1:0] IDX1 = rsd_pkg::CNT_W'(INDEX + 1);

  // strict compare keeps equal marks in arrival order
  assign swap_right = (ctrl.op == rsd_pkg::OP_SORT) && (ctrl.phase == PAR) &&
                      (IDX1 < ctrl.count) && (rec.mark < right_rec.mark);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      rsd_pkg::OP_HOLD: begin
      end
      rsd_pkg::OP_LOAD: begin
        if (ctrl.count == IDX) begin
          rec <= ctrl.din;
        end
      end
      rsd_pkg::OP_SORT: begin
        if (swap_right) begin
          rec <= right_rec;
        end else if (left_swap) begin
          rec <= left_rec;
        end
      end
      rsd_pkg::OP_ROTATE: begin
        if (IDX1 == ctrl.count) begin
          rec <= head_rec;
        end else if (IDX < ctrl.count) begin
          rec <= right_rec;
        end
      end
    endcase
  end

endmodule

### rtl/core/record_sort_descending.sv
// record table with stable descending sort over a row of compare cells
// load: result registered in the cycle after the item, one load item per cycle while the output is taken
// sort on n records: odd-even exchange, then n results at one per cycle while the output is taken
// empty sort and full load answer with one status result in the cycle after
// reset clears the record count, the control state and the output valid
// table contents are undefined until loaded
`timescale 1ns / 1ps

module record_sort_descending #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // roll_number, mark_value
  input  logic [0:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // out_roll, out_mark, rank_index, zero pad
  output logic [1:0]  m_tuser,   // status
  output logic        m_tlast
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  rsd_pkg::state_t    state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      step, step_next;
  rsd_pkg::cell_ctrl_t ctrl;

  logic               out_load;
  rsd_pkg::status_t   out_status;
  rsd_pkg::record_t   out_rec;
  logic [5:0]         out_rank;
  logic               out_last;

  rsd_pkg::status_t   status_next;
  rsd_pkg::record_t   rec_next;
  logic [5:0]         rank_next;
  logic               last_next;

  rsd_pkg::record_t   cell_rec  [TABLE_DEPTH];
  logic               cell_swap [TABLE_DEPTH];

  logic out_free;
  logic in_acc;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == rsd_pkg::S_IDLE) && out_free;
  assign in_acc   = s_tvalid && s_tready;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      rsd_cell #(.INDEX(g)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .left_rec   ((g == 0) ? cell_rec[0] : cell_rec[(g == 0) ? 0 : g - 1]),
        .right_rec  ((g == TABLE_DEPTH - 1) ? cell_rec[g] :
                     cell_rec[(g == TABLE_DEPTH - 1) ? g : g + 1]),
        .head_rec   (cell_rec[0]),
        .left_swap  ((g == 0) ? 1'b0 : cell_swap[(g == 0) ? 0 : g - 1]),
        .swap_right (cell_swap[g]),
        .rec        (cell_rec[g])
      );
    end
  endgenerate

  always_comb begin
    state_next  = state;
    count_next  = count;
    step_next   = step;
    out_load    = 1'b0;
    status_next = rsd_pkg::ST_RANKED;
    rec_next    = '0;
    rank_next   = '0;
    last_next   = 1'b1;
    ctrl.op     = rsd_pkg::OP_HOLD;
    ctrl.phase  = step[0];
    ctrl.count  = rsd_pkg::CNT_W'(count);
    ctrl.din.roll = s_tdata[31:0];
    ctrl.din.mark = s_tdata[63:32];
    unique case (state)
      rsd_pkg::S_IDLE: begin
        if (in_acc) begin
          if (s_tuser[0] == 1'b0) begin
            out_load = 1'b1;
            if (count == FULL) begin
              status_next = rsd_pkg::ST_FULL;
            end else begin
              status_next = rsd_pkg::ST_ACCEPTED;
              ctrl.op     = rsd_pkg::OP_LOAD;
              count_next  = count + CW'(1);
            end
          end else if (count == '0) begin
            out_load    = 1'b1;
            status_next = rsd_pkg::ST_EMPTY;
          end else begin
            state_next = rsd_pkg::S_SORT;
            step_next  = '0;
          end
        end
      end
      rsd_pkg::S_SORT: begin
        ctrl.op   = rsd_pkg::OP_SORT;
        step_next = step + CW'(1);
        if (step == count - CW'(1)) begin
          state_next = rsd_pkg::S_EMIT;
          step_next  = '0;
        end
      end
      rsd_pkg::S_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          status_next = rsd_pkg::ST_RANKED;
          rec_next    = cell_rec[0];
          rank_next   = 6'(step);
          last_next   = (step == count - CW'(1));
          ctrl.op     = rsd_pkg::OP_ROTATE;
          step_next   = step + CW'(1);
          if (last_next) begin
            state_next = rsd_pkg::S_IDLE;
            step_next  = '0;
          end
        end
      end
      default: begin
        state_next = rsd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rsd_pkg::S_IDLE;
      count    <= '0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= status_next;
      out_rec    <= rec_next;
      out_rank   <= rank_next;
      out_last   <= last_next;
    end
  end

  assign m_tdata = {2'b00, out_rank, out_rec.mark, out_rec.roll};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

endmodule

### sim/tb.sv
// self-checking testbench for the descending record sorter
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH = 64;
  localparam int RAND_ITEMS = 455;
  localparam int HOLD_LEN = 300;
  localparam int WATCHDOG = 4000;
  localparam logic FN_LOAD = 1'b0;
  localparam logic FN_SORT = 1'b1;

  typedef struct packed {
    rsd_pkg::status_t status;
    logic [31:0]      roll;
    logic [31:0]      mark;
    logic [5:0]       rank;
    logic             last;
  } outcome_t;

  typedef struct {
    logic        func;
    logic [31:0] roll;
    logic [31:0] mark;
    bit          typed;
    outcome_t    want;
  } entry_t;

  localparam outcome_t ACK    = '{rsd_pkg::ST_ACCEPTED, 32'h0, 32'h0, 6'd0, 1'b1};
  localparam outcome_t EMPTY  = '{rsd_pkg::ST_EMPTY, 32'h0, 32'h0, 6'd0, 1'b1};
  localparam outcome_t NO_EXP = '{rsd_pkg::ST_RANKED, 32'h0, 32'h0, 6'd0, 1'b0};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  logic [31:0]        tbl_roll [DEPTH];
  logic signed [31:0] tbl_mark [DEPTH];
  int                 tbl_count = 0;
  outcome_t           fresh[$];
  outcome_t           due[$];
  int                 errors = 0;
  bit                 gaps_on = 1'b1;
  bit                 hold_req = 1'b0;

  // loads, extremes, equal marks for stability, repeated sorts
  entry_t plan[] = '{
    '{FN_SORT, 32'h0000_0000, 32'h0000_0000, 1'b1, EMPTY},
    '{FN_LOAD, 32'h0000_0000, 32'h7fff_ffff, 1'b1, ACK},
    '{FN_SORT, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{rsd_pkg::ST_RANKED, 32'h0000_0000, 32'h7fff_ffff, 6'd0, 1'b1}},
    '{FN_LOAD, 32'hffff_ffff, 32'h8000_0000, 1'b1, ACK},
    '{FN_LOAD, 32'h1234_5678, 32'h0000_0000, 1'b1, ACK},
    '{FN_LOAD, 32'ha5a5_a5a5, 32'hffff_ffff, 1'b1, ACK},
    '{FN_LOAD, 32'h5a5a_5a5a, 32'h0000_0000, 1'b1, ACK},
    '{FN_LOAD, 32'h0000_0001, 32'h7fff_ffff, 1'b1, ACK},
    '{FN_SORT, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_EXP},
    '{FN_SORT, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_EXP},
    '{FN_LOAD, 32'h0000_0002, 32'h8000_0000, 1'b1, ACK},
    '{FN_LOAD, 32'h0000_0003, 32'h0000_0001, 1'b1, ACK},
    '{FN_LOAD, 32'h0000_0004, 32'h0000_0000, 1'b1, ACK},
    '{FN_SORT, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_EXP},
    '{FN_SORT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, NO_EXP}
  };

  record_sort_descending #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // table update and ranking for one accepted item
  task automatic rank_records(input logic func, input logic [31:0] roll,
                              input logic [31:0] mark);
    logic [31:0]        kr;
    logic signed [31:0] km;
    int                 j;
    fresh.delete();
    if (func == FN_LOAD) begin
      if (tbl_count == DEPTH) begin
        fresh.push_back('{rsd_pkg::ST_FULL, 32'h0, 32'h0, 6'd0, 1'b1});
      end else begin
        tbl_roll[tbl_count] = roll;
        tbl_mark[tbl_count] = mark;
        tbl_count++;
        fresh.push_back(ACK);
      end
    end else if (tbl_count == 0) begin
      fresh.push_back(EMPTY);
    end else begin
      // insertion sort, strict compare keeps equal marks in order
      for (int i = 1; i < tbl_count; i++) begin
        kr = tbl_roll[i];
        km = tbl_mark[i];
        j = i;
        while (j > 0 && tbl_mark[j-1] < km) begin
          tbl_roll[j] = tbl_roll[j-1];
          tbl_mark[j] = tbl_mark[j-1];
          j--;
        end
        tbl_roll[j] = kr;
        tbl_mark[j] = km;
      end
      for (int i = 0; i < tbl_count; i++) begin
        fresh.push_back('{rsd_pkg::ST_RANKED, tbl_roll[i], tbl_mark[i], 6'(i),
                          1'(i == tbl_count - 1)});
      end
    end
  endtask

  task automatic offer(input entry_t e);
    while (gaps_on && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= e.func;
    s_tdata  <= {e.mark, e.roll};
    do @(posedge clk); while (!s_tready);
    rank_records(e.func, e.roll, e.mark);
    if (e.typed) begin
      due.push_back(e.want);
    end else begin
      foreach (fresh[i]) due.push_back(fresh[i]);
    end
  endtask

  function automatic logic [31:0] pick_mark();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return 32'($urandom_range(8)) - 32'd4;
      3: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: begin
        if (tbl_count == 0) return $urandom;
        return tbl_mark[$urandom_range(tbl_count - 1)];
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_roll();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // result sink with random stalls and one long hold-off
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      m_tready <= !gaps_on || ($urandom_range(99) >= 34);
    end
  end

  // result checker
  initial begin
    outcome_t got;
    outcome_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = '{rsd_pkg::status_t'(m_tuser), m_tdata[31:0], m_tdata[63:32],
                m_tdata[69:64], m_tlast};
        if (due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected item: status %0d roll %h mark %h rank %0d last %b",
                     got.status, got.roll, got.mark, got.rank, got.last);
          end
        end else begin
          want = due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: want status %0d roll %h mark %h rank %0d last %b",
                       want.status, want.roll, want.mark, want.rank, want.last);
              $display("          got  status %0d roll %h mark %h rank %0d last %b",
                       got.status, got.roll, got.mark, got.rank, got.last);
            end
          end
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    entry_t e;
    bit     sort_it;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) offer(plan[i]);

    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == 120) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (due.size() != 0);
      end
      if (k == 200) hold_req = 1'b1;
      gaps_on = !(k >= 260 && k < 340);
      sort_it = (k == 200) ||
                ($urandom_range(99) < ((tbl_count < DEPTH) ? 12 : 20));
      e.func  = sort_it ? FN_SORT : FN_LOAD;
      e.roll  = pick_roll();
      e.mark  = pick_mark();
      e.typed = 1'b0;
      e.want  = NO_EXP;
      offer(e);
    end
    s_tvalid <= 1'b0;
    gaps_on = 1'b1;

    do @(posedge clk); while (due.size() != 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
